// ===== rtl/core/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types, codes and sizes for the packed pixel access block.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);

  // request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // colour modes
  localparam logic [1:0] MODE_MONO   = 2'd0;
  localparam logic [1:0] MODE_RGB565 = 2'd1;
  localparam logic [1:0] MODE_ARGB   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // classified operations handed to the back end
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        pixel_in;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        outside;
  } rsp_t;

  typedef struct packed {
    logic [7:0] frame_width;
    logic [7:0] frame_height;
    logic [1:0] colour_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              outside;
    logic [1:0]        mode;
    logic [4:0]        shift;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       pixel_in;
  } entry_t;

endpackage

// ===== rtl/core/ppa_front.sv =====
// ----------------------------------------------------------------------------
// ppa_front
// Classifies a request: bounds check, word address and bit position.
// ----------------------------------------------------------------------------
module ppa_front (
  input  ppa_pkg::req_t   req,
  input  ppa_pkg::cfg_t   cfg,
  output ppa_pkg::entry_t entry
);

  always_comb begin
    logic [15:0] w_eff;
    logic [15:0] h_eff;
    logic [15:0] w_last;
    logic [15:0] xu;
    logic [15:0] yu;
    logic [15:0] col;
    logic [31:0] addr_full;
    logic        out_of;

    // register values above the store size count as the store size
    w_eff = ({8'b0, cfg.frame_width} > 16'(ppa_pkg::MAX_WIDTH)) ?
            16'(ppa_pkg::MAX_WIDTH) : {8'b0, cfg.frame_width};
    h_eff = ({8'b0, cfg.frame_height} > 16'(ppa_pkg::MAX_HEIGHT)) ?
            16'(ppa_pkg::MAX_HEIGHT) : {8'b0, cfg.frame_height};
    w_last = w_eff - 16'd1;
    xu = req.pos_x;
    yu = req.pos_y;

    // negative coordinates have the sign bit set
    out_of = req.pos_x[15] | req.pos_y[15] | (xu >= w_eff) | (yu >= h_eff);

    // word index within the row, counted from the right end
    case (cfg.colour_mode)
      ppa_pkg::MODE_MONO: begin
        col         = (w_last >> 5) - (xu >> 5);
        entry.shift = ~xu[4:0];
      end
      ppa_pkg::MODE_RGB565: begin
        col         = (w_last >> 1) - (xu >> 1);
        entry.shift = xu[0] ? 5'd0 : 5'd16;
      end
      default: begin
        col         = w_last - xu;
        entry.shift = 5'd0;
      end
    endcase

    addr_full = 32'(yu) * 32'(ppa_pkg::MAX_WIDTH) + 32'(col);
    entry.addr     = addr_full[ppa_pkg::ADDR_W-1:0];
    entry.mode     = cfg.colour_mode;
    entry.pixel_in = req.pixel_in;
    entry.outside  = 1'b0;

    // operation select
    case (req.cmd)
      ppa_pkg::CMD_CLEAR: entry.op = ppa_pkg::OP_CLEAR;
      ppa_pkg::CMD_READ, ppa_pkg::CMD_WRITE: begin
        if (out_of) begin
          entry.op      = ppa_pkg::OP_NOP;
          entry.outside = 1'b1;
        end else if (cfg.colour_mode inside {ppa_pkg::MODE_MONO, ppa_pkg::MODE_RGB565,
                                             ppa_pkg::MODE_ARGB}) begin
          entry.op = (req.cmd == ppa_pkg::CMD_READ) ? ppa_pkg::OP_READ : ppa_pkg::OP_WRITE;
        end else begin
          entry.op = ppa_pkg::OP_NOP;
        end
      end
      default: entry.op = ppa_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/core/ppa_queue.sv =====
// ----------------------------------------------------------------------------
// ppa_queue
// Short request queue between the front and back end.
// ----------------------------------------------------------------------------
module ppa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppa_pkg::entry_t push_entry,
  input  logic            pop,
  output ppa_pkg::entry_t head,
  output logic            not_empty,
  output logic            full
);

  ppa_pkg::entry_t                slots [ppa_pkg::Q_DEPTH];
  logic [ppa_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ppa_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ppa_pkg::QCNT_W-1:0]     count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == ppa_pkg::QCNT_W'(ppa_pkg::Q_DEPTH));

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ppa_pkg::QPTR_W'(ppa_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ppa_pkg::QPTR_W'(ppa_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ppa_back.sv =====
// ----------------------------------------------------------------------------
// ppa_back
// Frame store and the sequencer that carries out reads, writes and clears.
// ----------------------------------------------------------------------------
module ppa_back (
  input  logic            clk,
  input  logic            rst,
  input  ppa_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            initializing,
  output logic            done,
  output ppa_pkg::rsp_t   rsp
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DATA  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [31:0]                 mem [ppa_pkg::DEPTH];
  logic [31:0]                 rd_data;
  logic                        mem_re;
  logic                        mem_we;
  logic [ppa_pkg::ADDR_W-1:0]  mem_ra;
  logic [ppa_pkg::ADDR_W-1:0]  mem_wa;
  logic [31:0]                 mem_wd;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [ppa_pkg::ADDR_W-1:0]  cnt;
  logic [ppa_pkg::ADDR_W-1:0]  cnt_next;
  ppa_pkg::entry_t             cur;
  ppa_pkg::entry_t             cur_next;
  logic                        strobe;
  ppa_pkg::rsp_t               rsp_next;

  logic [31:0]                 shifted;
  logic [31:0]                 read_val;
  logic [31:0]                 merged;
  logic                        sweep_last;

  assign initializing = (state == S_INIT);
  assign sweep_last   = (cnt == ppa_pkg::ADDR_W'(ppa_pkg::DEPTH - 1));

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // pixel extract and merge
  always_comb begin
    shifted = rd_data >> cur.shift;
    case (cur.mode)
      ppa_pkg::MODE_MONO:   read_val = {31'b0, shifted[0]};
      ppa_pkg::MODE_RGB565: read_val = {16'b0, shifted[15:0]};
      default:              read_val = rd_data;
    endcase
    merged = (cur.mode == ppa_pkg::MODE_ARGB) ? cur.pixel_in
                                              : (rd_data | (cur.pixel_in << cur.shift));
  end

  // sequencer
  always_comb begin
    pop        = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_ra     = head.addr;
    mem_wa     = cur.addr;
    mem_wd     = merged;
    state_next = state;
    cnt_next   = cnt;
    cur_next   = cur;
    strobe     = 1'b0;
    rsp_next   = '0;
    case (state)
      S_INIT: begin
        mem_we   = 1'b1;
        mem_wa   = cnt;
        mem_wd   = '0;
        cnt_next = cnt + 1'b1;
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop      = 1'b1;
          cur_next = head;
          case (head.op)
            ppa_pkg::OP_READ, ppa_pkg::OP_WRITE: begin
              mem_re     = 1'b1;
              state_next = S_DATA;
            end
            ppa_pkg::OP_CLEAR: begin
              cnt_next   = '0;
              state_next = S_CLEAR;
            end
            default: begin
              strobe           = 1'b1;
              rsp_next.outside = head.outside;
            end
          endcase
        end
      end
      S_DATA: begin
        strobe     = 1'b1;
        state_next = S_IDLE;
        if (cur.op == ppa_pkg::OP_WRITE) begin
          mem_we = 1'b1;
        end else begin
          rsp_next.pixel_out = read_val;
        end
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = cnt;
        mem_wd   = '0;
        cnt_next = cnt + 1'b1;
        if (sweep_last) begin
          strobe     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= strobe;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    rsp <= rsp_next;
  end

endmodule

// ===== rtl/core/packed_pixel_access.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_access
// Packed-pixel frame store with read, write and clear commands.
// ----------------------------------------------------------------------------
// After reset the store is zeroed by a sweep of all 16384 words (one word per
// cycle) with busy held high. A request is taken when start is high and busy
// is low; busy otherwise rises only when the two-entry request queue is full.
// Each request gives exactly one result, shown for one cycle with done high;
// results must be taken as they come. Reads and writes each make a registered
// read of the store and then extract or write back the pixel; the sequencer
// takes the next one only once the current one is done. Off-frame requests and
// unused codes are answered from the idle state with no store access; a clear
// walks all 16384 words. A read or write goes through the queue, the idle and
// data states and the done register. Configuration writes are always ready.
module packed_pixel_access (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ppa_pkg::req_t req,
  output logic          done,
  output ppa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  ppa_pkg::cfg_t   cfg;
  ppa_pkg::entry_t front_entry;
  ppa_pkg::entry_t head;
  logic            head_valid;
  logic            q_full;
  logic            pop;
  logic            initializing;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign busy      = q_full | initializing;
  assign accept    = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 8'd128;
      cfg.frame_height <= 8'd128;
      cfg.colour_mode  <= ppa_pkg::MODE_MONO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppa_pkg::REG_WIDTH:  cfg.frame_width  <= cfg_data;
        ppa_pkg::REG_HEIGHT: cfg.frame_height <= cfg_data;
        ppa_pkg::REG_MODE:   cfg.colour_mode  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ppa_front u_front (
    .req   (req),
    .cfg   (cfg),
    .entry (front_entry)
  );

  ppa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (head_valid),
    .full       (q_full)
  );

  ppa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .initializing (initializing),
    .done         (done),
    .rsp          (rsp)
  );

endmodule

// ===== rtl/core/ppa_checker.sv =====
// ----------------------------------------------------------------------------
// ppa_checker
// Port-level checks for the packed pixel access block.
// ----------------------------------------------------------------------------
module ppa_checker (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          done,
  input ppa_pkg::rsp_t rsp
);

  // reset starts the store sweep, which holds requests off
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // no result comes out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // a request outside the frame reads as zero
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.outside) |-> (rsp.pixel_out == 32'd0))
    else $error("outside result carries pixel data");

endmodule

bind packed_pixel_access ppa_checker u_ppa_checker (
  .clk  (clk),
  .rst  (rst),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
